// ----- src/ocn_pkg.sv -----
`default_nettype none

package ocn_pkg;

  localparam int unsigned NORM_W    = 16;
  localparam int unsigned CODE_W    = 16;
  localparam int unsigned ENC_MAG_W = NORM_W + 1;
  localparam int unsigned ENC_NUM_W = ENC_MAG_W + 1;
  localparam int unsigned QUO_W     = 31;
  localparam int unsigned ROOT_W    = (QUO_W + 1) / 2;

  typedef enum logic {
    CMD_ENCODE = 1'b0,
    CMD_DECODE = 1'b1
  } cmd_e;

  typedef struct packed {
    cmd_e cmd;
    logic zero;
    logic sign_x;
    logic sign_y;
    logic sign_z;
  } side_t;

endpackage

`default_nettype wire

// ----- src/ocn_if.sv -----
`default_nettype none

interface ocn_in_if import ocn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic              command;
  logic [NORM_W-1:0] in_normal_x;
  logic [NORM_W-1:0] in_normal_y;
  logic [NORM_W-1:0] in_normal_z;
  logic [CODE_W-1:0] in_code_u;
  logic [CODE_W-1:0] in_code_v;

  modport source (
    output valid, command, in_normal_x, in_normal_y, in_normal_z, in_code_u, in_code_v,
    input  ready
  );
  modport sink (
    input  valid, command, in_normal_x, in_normal_y, in_normal_z, in_code_u, in_code_v,
    output ready
  );
endinterface

interface ocn_out_if import ocn_pkg::*; ();
  logic              valid;
  logic              ready;
  logic [NORM_W-1:0] out_normal_x;
  logic [NORM_W-1:0] out_normal_y;
  logic [NORM_W-1:0] out_normal_z;
  logic [CODE_W-1:0] out_code_u;
  logic [CODE_W-1:0] out_code_v;
  logic              zero_vector;

  modport source (
    output valid, out_normal_x, out_normal_y, out_normal_z, out_code_u, out_code_v,
           zero_vector,
    input  ready
  );
  modport sink (
    input  valid, out_normal_x, out_normal_y, out_normal_z, out_code_u, out_code_v,
           zero_vector,
    output ready
  );
endinterface

`default_nettype wire

// ----- src/ocn_divider.sv -----
`default_nettype none

module ocn_divider import ocn_pkg::*; #(
  parameter int unsigned REM_W      = 33,
  parameter int unsigned QUO_STAGES = 31
) (
  input  logic                  clk_i,
  input  logic                  en_i,
  input  logic [REM_W-1:0]      rem_i,
  input  logic [QUO_STAGES-1:0] low_i,
  input  logic [REM_W-1:0]      div_i,
  output logic [QUO_STAGES-1:0] quo_o
);

  logic [REM_W-1:0]      rem_q [QUO_STAGES];
  logic [QUO_STAGES-1:0] low_q [QUO_STAGES];
  logic [REM_W-1:0]      div_q [QUO_STAGES];
  logic [QUO_STAGES-1:0] quo_q [QUO_STAGES];

  for (genvar k = 0; k < QUO_STAGES; k++) begin : g_stage
    logic [REM_W-1:0]      rem_p;
    logic [REM_W-1:0]      div_p;
    logic [QUO_STAGES-1:0] low_p;
    logic [QUO_STAGES-1:0] quo_p;
    logic [REM_W:0]        trial;
    logic                  take;

    if (k == 0) begin : g_first
      assign rem_p = rem_i;
      assign div_p = div_i;
      assign low_p = low_i;
      assign quo_p = '0;
    end else begin : g_next
      assign rem_p = rem_q[k-1];
      assign div_p = div_q[k-1];
      assign low_p = low_q[k-1];
      assign quo_p = quo_q[k-1];
    end

    assign trial = {rem_p, low_p[QUO_STAGES-1]};
    assign take  = trial >= {1'b0, div_p};

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k] <= take ? REM_W'(trial - {1'b0, div_p}) : REM_W'(trial);
        low_q[k] <= low_p << 1;
        div_q[k] <= div_p;
        quo_q[k] <= {quo_p[QUO_STAGES-2:0], take};
      end
    end
  end

  assign quo_o = quo_q[QUO_STAGES-1];

endmodule

`default_nettype wire

// ----- src/ocn_isqrt.sv -----
`default_nettype none

module ocn_isqrt import ocn_pkg::*; #(
  parameter int unsigned ROOT_BITS = 16
) (
  input  logic                   clk_i,
  input  logic                   en_i,
  input  logic [2*ROOT_BITS-1:0] rad_i,
  output logic [ROOT_BITS-1:0]   root_o
);

  localparam int unsigned RadW = 2 * ROOT_BITS;

  logic [RadW-1:0]      rem_q  [ROOT_BITS];
  logic [ROOT_BITS-1:0] root_q [ROOT_BITS];

  for (genvar k = 0; k < ROOT_BITS; k++) begin : g_stage
    localparam int unsigned B = ROOT_BITS - 1 - k;
    logic [RadW-1:0]      rem_p;
    logic [ROOT_BITS-1:0] root_p;
    logic [RadW-1:0]      trial;
    logic                 take;

    if (k == 0) begin : g_first
      assign rem_p  = rad_i;
      assign root_p = '0;
    end else begin : g_next
      assign rem_p  = rem_q[k-1];
      assign root_p = root_q[k-1];
    end

    assign trial = (RadW'(root_p) << (B + 1)) + (RadW'(1) << (2 * B));
    assign take  = rem_p >= trial;

    always_ff @(posedge clk_i) begin
      if (en_i) begin
        rem_q[k]  <= take ? rem_p - trial : rem_p;
        root_q[k] <= take ? (root_p | (ROOT_BITS'(1) << B)) : root_p;
      end
    end
  end

  assign root_o = root_q[ROOT_BITS-1];

endmodule

`default_nettype wire

// ----- src/octahedral_normal_codec.sv -----
// Octahedral normal codec, fully pipelined.
// in_i carries one word per item: command 0 encodes the Q2.14 vector
// in_normal_x/y/z into out_code_u/v, command 1 decodes in_code_u/v into a
// unit vector on out_normal_x/y/z. Fields of the other command read as zero;
// zero_vector flags an all-zero vector on encode.
// From input accept to output valid, a word passes through four front stages
// (magnitudes, folding, squares, divider setup), a 31-stage restoring
// divider that yields one quotient bit per stage, a 16-stage square root
// that yields one root bit per stage, and the output register. Throughput is
// one word per cycle unless stalled. in_i.ready is high whenever the output
// register is empty or being taken; while out_o.ready is low with a word
// waiting, the whole pipeline holds and in_i.ready drops, so nothing is lost
// or repeated. Reset clears all valid bits; the pipeline then accepts at once.
`default_nettype none

module octahedral_normal_codec import ocn_pkg::*; #(
  parameter int unsigned CODE_BITS = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  ocn_in_if.sink    in_i,
  ocn_out_if.source out_o
);

  localparam int unsigned CB        = CODE_BITS;
  localparam int unsigned MW        = CB + 1;
  localparam int unsigned SQW       = 2 * CB + 1;
  localparam int unsigned RW        = (SQW > ENC_NUM_W) ? SQW : ENC_NUM_W;
  localparam int unsigned EW        = QUO_W + RW;
  localparam int unsigned DEC_SHIFT = QUO_W - 1;
  localparam int unsigned ENC_SHIFT = QUO_W - 1 - CB;
  localparam logic [MW-1:0] FULL    = {1'b1, {CB{1'b0}}};

  typedef struct packed {
    side_t             side;
    logic [CODE_W-1:0] code_u;
    logic [CODE_W-1:0] code_v;
  } tail_t;

  logic out_valid_q;
  logic en;
  assign en       = !out_valid_q || out_o.ready;
  assign in_i.ready = en;

  // stage 1: magnitudes
  logic                 v1_q;
  cmd_e                 cmd1_q;
  logic [ENC_MAG_W-1:0] xe, ye, ze;
  logic [ENC_MAG_W-1:0] eax_d, eay_d, eaz_d;
  logic [ENC_MAG_W-1:0] eax1_q, eay1_q, eaz1_q;
  logic                 esx1_q, esy1_q, esz1_q;
  logic [CB-1:0]        u_d, w_d;
  logic [MW-1:0]        u2_d, w2_d, dax_d, day_d;
  logic [MW-1:0]        dax1_q, day1_q;
  logic                 dsx1_q, dsy1_q;

  assign xe    = {in_i.in_normal_x[NORM_W-1], in_i.in_normal_x};
  assign ye    = {in_i.in_normal_y[NORM_W-1], in_i.in_normal_y};
  assign ze    = {in_i.in_normal_z[NORM_W-1], in_i.in_normal_z};
  assign eax_d = xe[ENC_MAG_W-1] ? -xe : xe;
  assign eay_d = ye[ENC_MAG_W-1] ? -ye : ye;
  assign eaz_d = ze[ENC_MAG_W-1] ? -ze : ze;
  assign u_d   = CB'(in_i.in_code_u);
  assign w_d   = CB'(in_i.in_code_v);
  assign u2_d  = {u_d, 1'b0};
  assign w2_d  = {w_d, 1'b0};
  assign dax_d = u_d[CB-1] ? u2_d - FULL : FULL - u2_d;
  assign day_d = w_d[CB-1] ? w2_d - FULL : FULL - w2_d;

  always_ff @(posedge clk_i) begin
    if (en) begin
      cmd1_q <= cmd_e'(in_i.command);
      eax1_q <= eax_d;
      eay1_q <= eay_d;
      eaz1_q <= eaz_d;
      esx1_q <= xe[ENC_MAG_W-1];
      esy1_q <= ye[ENC_MAG_W-1];
      esz1_q <= ze[ENC_MAG_W-1];
      dax1_q <= dax_d;
      day1_q <= day_d;
      dsx1_q <= ~u_d[CB-1];
      dsy1_q <= ~w_d[CB-1];
    end
  end

  // stage 2: L1 norm and fold
  logic [ENC_MAG_W-1:0] es_d, es2_q;
  logic [ENC_NUM_W-1:0] s18_d, enu_d, env_d, enu2_q, env2_q;
  logic [MW:0]          dsum_d, full_x;
  logic                 dneg_d;
  logic [MW-1:0]        dfold_d, dmx_d, dmy_d, dmz_d;
  logic [MW-1:0]        dmx2_q, dmy2_q, dmz2_q;
  side_t                side2_d, side2_q;
  logic                 v2_q;

  assign es_d   = eax1_q + eay1_q + eaz1_q;
  assign s18_d  = ENC_NUM_W'(es_d);
  assign full_x = (MW + 1)'(FULL);
  assign dsum_d = (MW + 1)'(dax1_q) + (MW + 1)'(day1_q);
  assign dneg_d = dsum_d > full_x;
  assign dfold_d = dneg_d ? MW'(dsum_d - full_x) : '0;
  assign dmz_d  = dneg_d ? dfold_d : MW'(full_x - dsum_d);
  assign dmx_d  = dax1_q - dfold_d;
  assign dmy_d  = day1_q - dfold_d;

  always_comb begin
    if (esz1_q) begin
      enu_d = esx1_q ? ENC_NUM_W'(eay1_q) : (s18_d << 1) - ENC_NUM_W'(eay1_q);
      env_d = esy1_q ? ENC_NUM_W'(eax1_q) : (s18_d << 1) - ENC_NUM_W'(eax1_q);
    end else begin
      enu_d = esx1_q ? s18_d - ENC_NUM_W'(eax1_q) : s18_d + ENC_NUM_W'(eax1_q);
      env_d = esy1_q ? s18_d - ENC_NUM_W'(eay1_q) : s18_d + ENC_NUM_W'(eay1_q);
    end
    side2_d.cmd    = cmd1_q;
    side2_d.zero   = (cmd1_q == CMD_ENCODE) && (es_d == '0);
    side2_d.sign_x = dsx1_q;
    side2_d.sign_y = dsy1_q;
    side2_d.sign_z = dneg_d;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      es2_q   <= es_d;
      enu2_q  <= enu_d;
      env2_q  <= env_d;
      dmx2_q  <= dmx_d;
      dmy2_q  <= dmy_d;
      dmz2_q  <= dmz_d;
      side2_q <= side2_d;
    end
  end

  // stage 3: squares
  logic [SQW-1:0]       sq3_q [3];
  logic [ENC_MAG_W-1:0] es3_q;
  logic [ENC_NUM_W-1:0] enu3_q, env3_q;
  side_t                side3_q;
  logic                 v3_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      sq3_q[0] <= SQW'(dmx2_q) * SQW'(dmx2_q);
      sq3_q[1] <= SQW'(dmy2_q) * SQW'(dmy2_q);
      sq3_q[2] <= SQW'(dmz2_q) * SQW'(dmz2_q);
      es3_q    <= es2_q;
      enu3_q   <= enu2_q;
      env3_q   <= env2_q;
      side3_q  <= side2_q;
    end
  end

  // stage 4: divider operands
  logic [RW-1:0]    len2_d, div_d, div4_q;
  logic [EW-1:0]    dvd_d [3];
  logic [RW-1:0]    rem4_q [3];
  logic [QUO_W-1:0] low4_q [3];
  side_t            side4_q;
  logic             v4_q;

  assign len2_d = RW'(sq3_q[0]) + RW'(sq3_q[1]) + RW'(sq3_q[2]);

  always_comb begin
    if (side3_q.cmd == CMD_DECODE) begin
      div_d    = len2_d;
      dvd_d[0] = EW'(sq3_q[0]) << DEC_SHIFT;
      dvd_d[1] = EW'(sq3_q[1]) << DEC_SHIFT;
    end else begin
      div_d    = RW'(es3_q) << 1;
      dvd_d[0] = (EW'(enu3_q) << DEC_SHIFT) + (EW'(es3_q) << ENC_SHIFT);
      dvd_d[1] = (EW'(env3_q) << DEC_SHIFT) + (EW'(es3_q) << ENC_SHIFT);
    end
    dvd_d[2] = EW'(sq3_q[2]) << DEC_SHIFT;
  end

  always_ff @(posedge clk_i) begin
    if (en) begin
      div4_q  <= div_d;
      side4_q <= side3_q;
      for (int i = 0; i < 3; i++) begin
        rem4_q[i] <= dvd_d[i][EW-1:QUO_W];
        low4_q[i] <= dvd_d[i][QUO_W-1:0];
      end
    end
  end

  // divider
  logic [QUO_W-1:0] quo [3];

  for (genvar i = 0; i < 3; i++) begin : g_div
    ocn_divider #(
      .REM_W      (RW),
      .QUO_STAGES (QUO_W)
    ) u_div (
      .clk_i (clk_i),
      .en_i  (en),
      .rem_i (rem4_q[i]),
      .low_i (low4_q[i]),
      .div_i (div4_q),
      .quo_o (quo[i])
    );
  end

  side_t            side_a_q [QUO_W];
  logic [QUO_W-1:0] vld_a_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      side_a_q[0] <= side4_q;
      for (int k = 1; k < QUO_W; k++) begin
        side_a_q[k] <= side_a_q[k-1];
      end
    end
  end

  // encode codes: drop the extra quotient bits, saturate the top edge
  side_t             side_a;
  logic [CB:0]       cq_u, cq_v;
  logic [CB-1:0]     sat_u, sat_v;
  tail_t             tail_d;

  assign side_a = side_a_q[QUO_W-1];
  assign cq_u   = quo[0][ENC_SHIFT +: CB + 1];
  assign cq_v   = quo[1][ENC_SHIFT +: CB + 1];
  assign sat_u  = cq_u[CB] ? '1 : cq_u[CB-1:0];
  assign sat_v  = cq_v[CB] ? '1 : cq_v[CB-1:0];

  always_comb begin
    tail_d.side = side_a;
    if (side_a.cmd == CMD_ENCODE && !side_a.zero) begin
      tail_d.code_u = CODE_W'(sat_u);
      tail_d.code_v = CODE_W'(sat_v);
    end else begin
      tail_d.code_u = '0;
      tail_d.code_v = '0;
    end
  end

  // square root
  logic [ROOT_W-1:0] root [3];

  for (genvar i = 0; i < 3; i++) begin : g_sqrt
    ocn_isqrt #(
      .ROOT_BITS (ROOT_W)
    ) u_sqrt (
      .clk_i  (clk_i),
      .en_i   (en),
      .rad_i  ({1'b0, quo[i]}),
      .root_o (root[i])
    );
  end

  tail_t             tail_b_q [ROOT_W];
  logic [ROOT_W-1:0] vld_b_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      tail_b_q[0] <= tail_d;
      for (int k = 1; k < ROOT_W; k++) begin
        tail_b_q[k] <= tail_b_q[k-1];
      end
    end
  end

  // output stage: round to nearest, apply sign
  tail_t             tail_b;
  logic [ROOT_W:0]   rnd [3];
  logic [NORM_W-1:0] mag [3];
  logic [NORM_W-1:0] norm_d [3];
  logic [2:0]        sgn;

  assign tail_b = tail_b_q[ROOT_W-1];
  assign sgn    = {tail_b.side.sign_z, tail_b.side.sign_y, tail_b.side.sign_x};

  always_comb begin
    for (int i = 0; i < 3; i++) begin
      rnd[i] = (ROOT_W + 1)'(root[i]) + (ROOT_W + 1)'(1);
      mag[i] = NORM_W'(rnd[i][ROOT_W:1]);
      if (tail_b.side.cmd == CMD_DECODE) begin
        norm_d[i] = sgn[i] ? -mag[i] : mag[i];
      end else begin
        norm_d[i] = '0;
      end
    end
  end

  logic [NORM_W-1:0] nx_q, ny_q, nz_q;
  logic [CODE_W-1:0] cu_q, cv_q;
  logic              zv_q;

  always_ff @(posedge clk_i) begin
    if (en) begin
      nx_q <= norm_d[0];
      ny_q <= norm_d[1];
      nz_q <= norm_d[2];
      cu_q <= tail_b.code_u;
      cv_q <= tail_b.code_v;
      zv_q <= tail_b.side.zero;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      v1_q        <= 1'b0;
      v2_q        <= 1'b0;
      v3_q        <= 1'b0;
      v4_q        <= 1'b0;
      vld_a_q     <= '0;
      vld_b_q     <= '0;
      out_valid_q <= 1'b0;
    end else if (en) begin
      v1_q        <= in_i.valid;
      v2_q        <= v1_q;
      v3_q        <= v2_q;
      v4_q        <= v3_q;
      vld_a_q     <= {vld_a_q[QUO_W-2:0], v4_q};
      vld_b_q     <= {vld_b_q[ROOT_W-2:0], vld_a_q[QUO_W-1]};
      out_valid_q <= vld_b_q[ROOT_W-1];
    end
  end

  assign out_o.valid        = out_valid_q;
  assign out_o.out_normal_x = nx_q;
  assign out_o.out_normal_y = ny_q;
  assign out_o.out_normal_z = nz_q;
  assign out_o.out_code_u   = cu_q;
  assign out_o.out_code_v   = cv_q;
  assign out_o.zero_vector  = zv_q;

  a_zero_clears: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && out_o.zero_vector |->
      out_o.out_code_u == '0 && out_o.out_code_v == '0 && out_o.out_normal_x == '0 &&
      out_o.out_normal_y == '0 && out_o.out_normal_z == '0)
    else $error("zero vector result carries nonzero fields");

  a_decode_no_code: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_o.valid && (out_o.out_normal_x != '0 || out_o.out_normal_y != '0 ||
      out_o.out_normal_z != '0) |->
      out_o.out_code_u == '0 && out_o.out_code_v == '0 && !out_o.zero_vector)
    else $error("decode result carries code fields");

  a_quo_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    vld_a_q[QUO_W-1] && side_a.cmd == CMD_DECODE |->
      quo[0] <= (QUO_W'(1) << DEC_SHIFT) && quo[1] <= (QUO_W'(1) << DEC_SHIFT) &&
      quo[2] <= (QUO_W'(1) << DEC_SHIFT))
    else $error("decode quotient exceeds unit ratio");

endmodule

`default_nettype wire
